/* src/dns_pkg.sv */
package dns_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned SCORE_W = 22;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned REG_INDEX_W = 3;
  localparam logic [SCORE_W-1:0] SCORE_ONES = {SCORE_W{1'b1}};

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_DIRECTION    = 3'd0,
    REG_REF_X        = 3'd1,
    REG_REF_Y        = 3'd2,
    REG_REF_WIDTH    = 3'd3,
    REG_REF_HEIGHT   = 3'd4,
    REG_AREA_WIDTH   = 3'd5,
    REG_AREA_HEIGHT  = 3'd6,
    REG_REF_FLOATING = 3'd7
  } reg_index_t;

  typedef struct packed {
    dir_t               direction;
    logic signed [15:0] ref_x;
    logic signed [15:0] ref_y;
    logic [14:0]        ref_width;
    logic [14:0]        ref_height;
    logic [14:0]        area_width;
    logic [14:0]        area_height;
    logic               ref_floating;
  } cfg_t;

  typedef struct packed {
    logic               scored;
    logic               tie_wins;
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] index;
    logic               last;
  } entry_t;

endpackage

/* src/dns_front.sv */
module dns_front (
  input  dns_pkg::cfg_t                cfg,
  input  logic signed [15:0]           cand_x,
  input  logic signed [15:0]           cand_y,
  input  logic [14:0]                  cand_width,
  input  logic [14:0]                  cand_height,
  input  logic                         cand_visible,
  input  logic [dns_pkg::INDEX_W-1:0]  cand_index,
  input  logic                         is_last,
  output dns_pkg::entry_t              entry
);

  logic signed [17:0] rx;
  logic signed [17:0] ry;
  logic signed [17:0] cx;
  logic signed [17:0] cy;
  logic signed [17:0] gap;
  logic signed [17:0] gap_wrap;
  logic signed [17:0] span;
  logic signed [17:0] cross_diff;
  logic [16:0]        d1;
  logic [16:0]        d2;
  logic [16:0]        dmin;
  logic [16:0]        cross_mag;
  logic [22:0]        sum;

  always_comb begin
    rx = {{2{cfg.ref_x[15]}}, cfg.ref_x};
    ry = {{2{cfg.ref_y[15]}}, cfg.ref_y};
    cx = {{2{cand_x[15]}}, cand_x};
    cy = {{2{cand_y[15]}}, cand_y};
    unique case (cfg.direction)
      dns_pkg::DIR_LEFT: begin
        gap        = rx - cx - {3'b000, cand_width};
        span       = {3'b000, cfg.area_width};
        cross_diff = ry - cy;
      end
      dns_pkg::DIR_RIGHT: begin
        gap        = cx - rx - {3'b000, cfg.ref_width};
        span       = {3'b000, cfg.area_width};
        cross_diff = cy - ry;
      end
      dns_pkg::DIR_UP: begin
        gap        = ry - cy - {3'b000, cand_height};
        span       = {3'b000, cfg.area_height};
        cross_diff = rx - cx;
      end
      default: begin
        gap        = cy - ry - {3'b000, cfg.ref_height};
        span       = {3'b000, cfg.area_height};
        cross_diff = cx - rx;
      end
    endcase
    gap_wrap  = gap + span;
    d1        = gap[17] ? 17'(-gap) : gap[16:0];
    d2        = gap_wrap[17] ? 17'(-gap_wrap) : gap_wrap[16:0];
    dmin      = (d1 < d2) ? d1 : d2;
    cross_mag = cross_diff[17] ? 17'(-cross_diff) : cross_diff[16:0];
    // times 20 as 16 + 4
    sum = {2'b00, dmin, 4'b0000} + {4'b0000, dmin, 2'b00} + {6'b000000, cross_mag};

    entry.scored   = cand_visible && !cfg.ref_floating;
    entry.tie_wins = (cfg.direction == dns_pkg::DIR_LEFT) || (cfg.direction == dns_pkg::DIR_UP);
    entry.score    = sum[22] ? dns_pkg::SCORE_ONES : sum[dns_pkg::SCORE_W-1:0];
    entry.index    = cand_index;
    entry.last     = is_last;
  end

endmodule

/* src/dns_queue.sv */
module dns_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dns_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dns_pkg::entry_t pop_data
);

  dns_pkg::entry_t                 mem [dns_pkg::QUEUE_DEPTH];
  logic [dns_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [dns_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [dns_pkg::QUEUE_PTR_W:0]   count;
  logic                            push;
  logic                            pop;

  assign push_ready = count != (dns_pkg::QUEUE_PTR_W+1)'(dns_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/dns_back.sv */
module dns_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  dns_pkg::entry_t              head,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [dns_pkg::INDEX_W-1:0]  best_index,
  output logic [dns_pkg::SCORE_W-1:0]  best_score
);

  logic [dns_pkg::SCORE_W-1:0] run_score;
  logic [dns_pkg::INDEX_W-1:0] run_index;
  logic                        run_found;
  logic                        better;
  logic                        take;
  logic [dns_pkg::SCORE_W-1:0] upd_score;
  logic [dns_pkg::INDEX_W-1:0] upd_index;
  logic                        upd_found;
  logic                        pop;

  always_comb begin
    better    = head.tie_wins ? (head.score <= run_score) : (head.score < run_score);
    take      = head.scored && better;
    upd_score = take ? head.score : run_score;
    upd_index = take ? head.index : run_index;
    upd_found = take || run_found;
    pop_ready = !head.last || !out_valid || out_ready;
    pop       = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      found      <= upd_found;
      best_index <= upd_index;
      best_score <= upd_score;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_score <= dns_pkg::SCORE_ONES;
      run_index <= '0;
      run_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.last) begin
          out_valid <= 1'b1;
          run_score <= dns_pkg::SCORE_ONES;
          run_index <= '0;
          run_found <= 1'b0;
        end else begin
          run_score <= upd_score;
          run_index <= upd_index;
          run_found <= upd_found;
        end
      end
    end
  end

endmodule

/* src/directional_neighbor_select.sv */
// directional neighbor select
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the direction,
// reference rectangle, area size and floating flag; cfg_ready is always high.
// write configuration only while no search transaction is in flight.
// input channel (in_valid/in_ready) takes one candidate rectangle per
// transaction; the front scores it in the accepting cycle and places it in a
// four-entry queue. the back keeps the running best and, on the candidate
// marked is_last, loads one result transaction (found, best_index, best_score)
// into the output register for out_valid/out_ready.
// a last candidate goes through a queue entry and then the output register to out_valid.
// throughput: one candidate per cycle while the queue is not full, set by the
// combinational score path and the compare in the back.
// when out_ready is low and a result waits, the back holds the next last
// candidate in the queue; non-last candidates still drain, and in_ready drops
// only once the queue is full.
// reset clears the configuration registers to zero, the running best to not found
// with an all-ones score, and empties the queue and the output register.
module directional_neighbor_select (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dns_pkg::REG_INDEX_W-1:0]  cfg_index,
  input  logic [dns_pkg::DATA_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               cand_x,
  input  logic signed [15:0]               cand_y,
  input  logic [14:0]                      cand_width,
  input  logic [14:0]                      cand_height,
  input  logic                             cand_visible,
  input  logic [dns_pkg::INDEX_W-1:0]      cand_index,
  input  logic                             is_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             found,
  output logic [dns_pkg::INDEX_W-1:0]      best_index,
  output logic [dns_pkg::SCORE_W-1:0]      best_score
);

  dns_pkg::cfg_t   cfg;
  dns_pkg::entry_t front_entry;
  dns_pkg::entry_t head;
  logic            head_valid;
  logic            head_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction    <= dns_pkg::DIR_LEFT;
      cfg.ref_x        <= '0;
      cfg.ref_y        <= '0;
      cfg.ref_width    <= '0;
      cfg.ref_height   <= '0;
      cfg.area_width   <= '0;
      cfg.area_height  <= '0;
      cfg.ref_floating <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dns_pkg::reg_index_t'(cfg_index))
        dns_pkg::REG_DIRECTION:    cfg.direction    <= dns_pkg::dir_t'(cfg_data[1:0]);
        dns_pkg::REG_REF_X:        cfg.ref_x        <= cfg_data;
        dns_pkg::REG_REF_Y:        cfg.ref_y        <= cfg_data;
        dns_pkg::REG_REF_WIDTH:    cfg.ref_width    <= cfg_data[14:0];
        dns_pkg::REG_REF_HEIGHT:   cfg.ref_height   <= cfg_data[14:0];
        dns_pkg::REG_AREA_WIDTH:   cfg.area_width   <= cfg_data[14:0];
        dns_pkg::REG_AREA_HEIGHT:  cfg.area_height  <= cfg_data[14:0];
        dns_pkg::REG_REF_FLOATING: cfg.ref_floating <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dns_front u_front (
    .cfg          (cfg),
    .cand_x       (cand_x),
    .cand_y       (cand_y),
    .cand_width   (cand_width),
    .cand_height  (cand_height),
    .cand_visible (cand_visible),
    .cand_index   (cand_index),
    .is_last      (is_last),
    .entry        (front_entry)
  );

  dns_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head)
  );

  dns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .head       (head),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .best_index (best_index),
    .best_score (best_score)
  );

endmodule
